/* hdl/ubx_pkg.sv */
// Shared constants for the UBX frame receiver: payload store depth, parse
// phase codes, status and command codes, register indexes.
// No dependencies.
`default_nettype none

package ubx_pkg;

  localparam int PAYLOAD_DEPTH = 92;
  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  localparam int REG_SYNC_FIRST  = 0;
  localparam int REG_SYNC_SECOND = 1;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  localparam logic [2:0] ST_TAKEN    = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_DROPPED  = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;

endpackage

`default_nettype wire

/* hdl/ubx_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ubx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 92
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/ubx_frame_receiver_top.sv */
// Top level of the UBX frame receiver: byte parser, Fletcher-8 check,
// payload store and output stages. Uses ubx_pkg and ubx_ram.
`default_nettype none

// Takes one item per clock cycle when the output side keeps up; each item
// yields exactly one result item, carried through stage 1 and the output
// register. The parse state sits in registers and is updated in the cycle of
// acceptance; payload bytes go to a RAM with a registered read, so a payload
// read crosses one stage before the output register. A write and a later
// read of the same entry never overlap, since the write lands at the edge
// of acceptance. The payload store has no reset and needs no clearing pass:
// only entries below the current payload count are ever returned.
module ubx_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // result out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [7:0] msg_class, [15:8] msg_id,
                                       // [31:16] payload_length, [39:32] read_data
  output logic      [3:0]  out_tuser,  // [2:0] status, [3] frame_ready
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int IDX_W = ubx_pkg::IDX_W;
  localparam int CNT_W = ubx_pkg::CNT_W;

  // configuration registers
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = {24'd0, cfg_paddr[2] ? sync_second_r : sync_first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= ubx_pkg::SYNC_FIRST_RST;
      sync_second_r <= ubx_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == 1'(ubx_pkg::REG_SYNC_SECOND)) begin
        sync_second_r <= cfg_pwdata[7:0];
      end else begin
        sync_first_r <= cfg_pwdata[7:0];
      end
    end
  end

  // item fields
  logic [1:0] in_command;
  logic [7:0] in_rx_byte;
  logic [6:0] in_read_index;

  assign in_command    = in_tuser[1:0];
  assign in_rx_byte    = in_tdata[7:0];
  assign in_read_index = in_tdata[14:8];

  // parse state
  logic [3:0]       phase_r,  phase_nxt;
  logic [7:0]       sum_a_r,  sum_a_nxt;
  logic [7:0]       sum_b_r,  sum_b_nxt;
  logic [7:0]       class_r,  class_nxt;
  logic [7:0]       ident_r,  ident_nxt;
  logic [15:0]      length_r, length_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [7:0]       ck_lo_r,  ck_lo_nxt;
  logic             ready_r,  ready_nxt;
  logic [2:0]       status;

  // pipeline stages
  logic        s1_valid_r;
  logic [3:0]  s1_tuser_r;
  logic [31:0] s1_hdr_r;
  logic        s1_hit_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic [39:0] out_tdata_r;
  logic [3:0]  out_tuser_r;
  logic        in_acc;

  // payload store access
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic             rd_hit;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       add_a;

  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;
  assign in_acc    = in_tvalid & in_tready;

  assign count_inc = count_r + 1'b1;
  assign add_a     = sum_a_r + in_rx_byte;
  assign rd_hit    = 32'(in_read_index) < 32'(count_r);

  always_comb begin
    phase_nxt  = phase_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    class_nxt  = class_r;
    ident_nxt  = ident_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    ck_lo_nxt  = ck_lo_r;
    ready_nxt  = ready_r;
    status     = ubx_pkg::ST_TAKEN;
    ram_we     = 1'b0;
    case (in_command)
      ubx_pkg::CMD_BYTE: begin
        if (ready_r) begin
          status = ubx_pkg::ST_DROPPED;
        end else begin
          case (phase_r)
            ubx_pkg::PH_SYNC1: begin
              if (in_rx_byte == sync_first_r) phase_nxt = ubx_pkg::PH_SYNC2;
            end
            ubx_pkg::PH_SYNC2: begin
              phase_nxt = (in_rx_byte == sync_second_r) ? ubx_pkg::PH_CLASS
                                                        : ubx_pkg::PH_SYNC1;
            end
            ubx_pkg::PH_CLASS: begin
              sum_a_nxt  = in_rx_byte;
              sum_b_nxt  = in_rx_byte;
              length_nxt = 16'd0;
              count_nxt  = '0;
              class_nxt  = in_rx_byte;
              phase_nxt  = ubx_pkg::PH_ID;
            end
            ubx_pkg::PH_ID: begin
              ident_nxt = in_rx_byte;
              sum_a_nxt = add_a;
              sum_b_nxt = sum_b_r + add_a;
              phase_nxt = ubx_pkg::PH_LEN_LO;
            end
            ubx_pkg::PH_LEN_LO: begin
              length_nxt = {8'd0, in_rx_byte};
              sum_a_nxt  = add_a;
              sum_b_nxt  = sum_b_r + add_a;
              phase_nxt  = ubx_pkg::PH_LEN_HI;
            end
            ubx_pkg::PH_LEN_HI: begin
              length_nxt = {in_rx_byte, length_r[7:0]};
              sum_a_nxt  = add_a;
              sum_b_nxt  = sum_b_r + add_a;
              phase_nxt  = ({in_rx_byte, length_r[7:0]} == 16'd0) ? ubx_pkg::PH_CK_A
                                                                  : ubx_pkg::PH_PAYLOAD;
            end
            ubx_pkg::PH_PAYLOAD: begin
              ram_we    = 32'(count_r) < ubx_pkg::PAYLOAD_DEPTH;
              count_nxt = count_inc;
              sum_a_nxt = add_a;
              sum_b_nxt = sum_b_r + add_a;
              if (16'(count_inc) == length_r) begin
                phase_nxt = ubx_pkg::PH_CK_A;
              end else if (32'(count_inc) >= ubx_pkg::PAYLOAD_DEPTH) begin
                phase_nxt = ubx_pkg::PH_SYNC1;
                status    = ubx_pkg::ST_OVERFLOW;
              end
            end
            ubx_pkg::PH_CK_A: begin
              ck_lo_nxt = in_rx_byte;
              phase_nxt = ubx_pkg::PH_CK_B;
            end
            ubx_pkg::PH_CK_B: begin
              if (ck_lo_r == sum_a_r && in_rx_byte == sum_b_r) begin
                ready_nxt = 1'b1;
                status    = ubx_pkg::ST_GOOD;
              end else begin
                status = ubx_pkg::ST_BAD;
              end
              phase_nxt = ubx_pkg::PH_SYNC1;
            end
            default: phase_nxt = ubx_pkg::PH_SYNC1;
          endcase
        end
      end
      ubx_pkg::CMD_READ:    status = ubx_pkg::ST_READ;
      ubx_pkg::CMD_RELEASE: begin
        ready_nxt = 1'b0;
        status    = ubx_pkg::ST_RELEASED;
      end
      default: status = ubx_pkg::ST_DROPPED;
    endcase
  end

  assign ram_re = in_acc & (in_command == ubx_pkg::CMD_READ) & rd_hit;

  ubx_ram #(
    .WIDTH (8),
    .DEPTH (ubx_pkg::PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (in_acc & ram_we),
    .waddr (IDX_W'(count_r)),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (IDX_W'(in_read_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ubx_pkg::PH_SYNC1;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      class_r  <= 8'd0;
      ident_r  <= 8'd0;
      length_r <= 16'd0;
      count_r  <= '0;
      ck_lo_r  <= 8'd0;
      ready_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      class_r  <= class_nxt;
      ident_r  <= ident_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      ck_lo_r  <= ck_lo_nxt;
      ready_r  <= ready_nxt;
    end
  end

  // stage 1: wait for the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tuser_r <= {ready_nxt, status};
      s1_hdr_r   <= {length_nxt, ident_nxt, class_nxt};
      s1_hit_r   <= ram_re;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tuser_r <= s1_tuser_r;
      out_tdata_r <= {s1_hit_r ? ram_rdata : 8'd0, s1_hdr_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_ready_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> phase_r == ubx_pkg::PH_SYNC1)
    else $error("frame ready outside sync hunt");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= ubx_pkg::PAYLOAD_DEPTH)
    else $error("payload count beyond store depth");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ram_we) |-> (phase_r == ubx_pkg::PH_PAYLOAD && !ready_r))
    else $error("payload write outside payload phase");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> 32'(in_read_index) < ubx_pkg::PAYLOAD_DEPTH)
    else $error("payload read beyond store depth");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for ubx_frame_receiver_top: drives commands and frame bytes on the
// item stream, predicts each result in SV and compares it field by field.
// Depends on ubx_pkg and the receiver RTL.

module tb_top;
  import ubx_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SCRIPT_LEN = 28;

  typedef struct packed {
    logic [2:0]  status;
    logic        ready;
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [15:0] len;
    logic [7:0]  rdata;
  } rx_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic [6:0] idx;
    logic       given;
    rx_result_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predicted receiver state
  logic [7:0]       sync1_val = SYNC_FIRST_RST;
  logic [7:0]       sync2_val = SYNC_SECOND_RST;
  logic [3:0]       rx_phase = PH_SYNC1;
  logic [7:0]       fl_a = '0;
  logic [7:0]       fl_b = '0;
  logic [7:0]       cur_class = '0;
  logic [7:0]       cur_ident = '0;
  logic [15:0]      cur_len = '0;
  logic [CNT_W-1:0] stored_count = '0;
  logic [7:0]       ck_lo = '0;
  logic [7:0]       pay_mem [PAYLOAD_DEPTH];
  logic             frame_held = 1'b0;

  rx_result_t pending_results [$];
  rx_result_t seen, due;
  step_row_t  script [SCRIPT_LEN];
  int         fail_count = 0;
  int         items_done = 0;
  int         quiet_cycles = 0;
  bit         calm = 1'b0;
  logic [7:0] sync_pick;

  ubx_frame_receiver_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rx_result_t parse_item(input logic [1:0] cmd, input logic [7:0] data,
                                            input logic [6:0] idx);
    rx_result_t r;
    logic [3:0] was;
    r = '0;
    r.status = ST_TAKEN;
    was = rx_phase;
    case (cmd)
      CMD_BYTE: begin
        if (frame_held) begin
          r.status = ST_DROPPED;
        end else begin
          case (rx_phase)
            PH_SYNC1: rx_phase = (data == sync1_val) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: rx_phase = (data == sync2_val) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: begin
              fl_a = '0;
              fl_b = '0;
              cur_len = '0;
              stored_count = '0;
              cur_class = data;
              rx_phase = PH_ID;
            end
            PH_ID: begin
              cur_ident = data;
              rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              cur_len = {8'h00, data};
              rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              cur_len[15:8] = data;
              rx_phase = (cur_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              if (stored_count < PAYLOAD_DEPTH) pay_mem[stored_count] = data;
              stored_count = stored_count + 1'b1;
              if (stored_count == cur_len) begin
                rx_phase = PH_CK_A;
              end else if (stored_count >= PAYLOAD_DEPTH) begin
                rx_phase = PH_SYNC1;
                r.status = ST_OVERFLOW;
              end
            end
            PH_CK_A: begin
              ck_lo = data;
              rx_phase = PH_CK_B;
            end
            PH_CK_B: begin
              if (ck_lo == fl_a && data == fl_b) begin
                frame_held = 1'b1;
                r.status = ST_GOOD;
              end else begin
                r.status = ST_BAD;
              end
              rx_phase = PH_SYNC1;
            end
            default: rx_phase = PH_SYNC1;
          endcase
          if (was >= PH_CLASS && was <= PH_PAYLOAD) begin
            fl_a = fl_a + data;
            fl_b = fl_b + fl_a;
          end
        end
      end
      CMD_READ: begin
        if (idx < stored_count && idx < PAYLOAD_DEPTH) r.rdata = pay_mem[idx];
        r.status = ST_READ;
      end
      CMD_RELEASE: begin
        frame_held = 1'b0;
        r.status = ST_RELEASED;
      end
      default: r.status = ST_DROPPED;
    endcase
    r.ready = frame_held;
    r.cls = cur_class;
    r.ident = cur_ident;
    r.len = cur_len;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic [6:0] idx,
                           input logic given, input rx_result_t want);
    rx_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, idx, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = parse_item(cmd, data, idx);
    pending_results.push_back(given ? want : predicted);
    items_done++;
  endtask

  task automatic send_frame();
    int len, n, k, pick;
    logic [7:0] b, sa, sb;
    logic [7:0] hdr [4];
    bit cut;
    repeat ($urandom_range(0, 2)) begin
      pick = $urandom_range(0, 9);
      send_item((pick == 0) ? CMD_UNUSED : CMD_BYTE, 8'($urandom_range(0, 255)),
                7'($urandom_range(0, 91)), 1'b0, '0);
    end
    send_item(CMD_BYTE, sync1_val, 7'($urandom_range(0, 91)), 1'b0, '0);
    send_item(CMD_BYTE, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : sync2_val,
              7'($urandom_range(0, 91)), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 55) len = $urandom_range(0, 8);
    else if (pick < 75) len = $urandom_range(9, 40);
    else if (pick < 88) len = $urandom_range(85, 92);
    else if (pick < 96) len = $urandom_range(93, 400);
    else len = 65535;
    hdr[0] = 8'($urandom_range(0, 255));
    hdr[1] = 8'($urandom_range(0, 255));
    hdr[2] = 8'(len);
    hdr[3] = 8'(len >> 8);
    sa = '0;
    sb = '0;
    for (k = 0; k < 4; k++) begin
      sa = sa + hdr[k];
      sb = sb + sa;
      send_item(CMD_BYTE, hdr[k], 7'($urandom_range(0, 91)), 1'b0, '0);
    end
    n = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : len;
    cut = ($urandom_range(0, 19) == 0);
    if (cut) n = $urandom_range(0, n);
    for (k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      sa = sa + b;
      sb = sb + sa;
      send_item(CMD_BYTE, b, 7'($urandom_range(0, 91)), 1'b0, '0);
    end
    if (!cut && len <= PAYLOAD_DEPTH) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) sa = sa ^ 8'($urandom_range(1, 255));
        else sb = sb ^ 8'($urandom_range(1, 255));
      end
      send_item(CMD_BYTE, sa, 7'($urandom_range(0, 91)), 1'b0, '0);
      send_item(CMD_BYTE, sb, 7'($urandom_range(0, 91)), 1'b0, '0);
    end
    repeat ($urandom_range(0, 3) + (frame_held ? 1 : 0)) begin
      send_item(CMD_READ, 8'($urandom_range(0, 255)),
                7'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 91)
                                               : $urandom_range(0, (n > 0) ? n - 1 : 0)),
                1'b0, '0);
    end
    if (frame_held && $urandom_range(0, 3) == 0)
      send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 91)), 1'b0, '0);
    if (frame_held ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0))
      send_item(CMD_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 91)), 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input int reg_idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * reg_idx);
    cfg_pwdata <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_SYNC_FIRST) sync1_val = value;
    else if (reg_idx == REG_SYNC_SECOND) sync2_val = value;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = out_tuser[2:0];
      seen.ready = out_tuser[3];
      seen.cls = out_tdata[7:0];
      seen.ident = out_tdata[15:8];
      seen.len = out_tdata[31:16];
      seen.rdata = out_tdata[39:32];
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none, actual %h", $time, seen);
      end else begin
        due = pending_results.pop_front();
        check_field("status", 16'(due.status), 16'(seen.status));
        check_field("frame_ready", 16'(due.ready), 16'(seen.ready));
        check_field("msg_class", 16'(due.cls), 16'(seen.cls));
        check_field("msg_id", 16'(due.ident), 16'(seen.ident));
        check_field("payload_length", due.len, seen.len);
        check_field("read_data", 16'(due.rdata), 16'(seen.rdata));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    script = '{
      '{CMD_READ,    8'h00,           7'd0,  1'b1, '{ST_READ,     1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_UNUSED,  8'hFF,           7'd91, 1'b1, '{ST_DROPPED,  1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_RELEASE, 8'h00,           7'd0,  1'b1, '{ST_RELEASED, 1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    SYNC_FIRST_RST,  7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'hFF,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    SYNC_FIRST_RST,  7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    SYNC_SECOND_RST, 7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h00, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h01,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h01, 8'h00, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h07,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h08,           7'd0,  1'b1, '{ST_TAKEN,    1'b0, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    8'h19,           7'd0,  1'b1, '{ST_GOOD,     1'b1, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    SYNC_FIRST_RST,  7'd0,  1'b1, '{ST_DROPPED,  1'b1, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_RELEASE, 8'h00,           7'd0,  1'b1, '{ST_RELEASED, 1'b0, 8'h01, 8'h07, 16'h0, 8'h00}},
      '{CMD_BYTE,    SYNC_FIRST_RST,  7'd0,  1'b0, '0},
      '{CMD_BYTE,    SYNC_SECOND_RST, 7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'hFF,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h02,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'hFF,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h00,           7'd0,  1'b0, '0},
      '{CMD_BYTE,    8'h01,           7'd0,  1'b0, '0},
      '{CMD_READ,    8'h00,           7'd0,  1'b0, '0},
      '{CMD_READ,    8'h00,           7'd91, 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[i])
      send_item(script[i].cmd, script[i].data, script[i].idx, script[i].given, script[i].want);
    while (items_done < 340) send_frame();
    drain();
    cfg_write(REG_SYNC_FIRST, 8'h00);
    cfg_write(REG_SYNC_SECOND, 8'hFF);
    calm = 1'b1;
    while (items_done < 680) send_frame();
    drain();
    calm = 1'b0;
    cfg_write(REG_SYNC_FIRST, 8'hFF);
    cfg_write(REG_SYNC_SECOND, 8'h00);
    while (items_done < 1020) send_frame();
    drain();
    sync_pick = 8'($urandom_range(0, 255));
    cfg_write(REG_SYNC_FIRST, sync_pick);
    cfg_write(REG_SYNC_SECOND, sync_pick);
    while (items_done < 1360) send_frame();
    drain();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
